FILE: rtl/core/cpbpwm_pkg.sv
// ----------------------------------------------------------------------------
// cpbpwm_pkg
// Shared constants, tables and types of the charlieplexed breathing driver.
// ----------------------------------------------------------------------------
package cpbpwm_pkg;

	localparam int SLOT_MAX      = 6;
	localparam int LED_COUNT_DEF = 6;
	localparam int SLOT_W        = 3;
	localparam int PIN_W         = 3;
	localparam int LEVEL_W       = 8;
	localparam int LEVEL_STEPS   = 5;
	localparam int INTERVAL_W    = 16;
	localparam int PHASE_W       = 4;
	localparam int IN_DATA_W     = 8;
	localparam int OUT_DATA_W    = 16;
	localparam int APB_ADDR_W    = 5;
	localparam int APB_DATA_W    = 32;

	localparam logic [PIN_W-1:0] DIR_PATTERN [SLOT_MAX] =
		'{3'b011, 3'b011, 3'b101, 3'b101, 3'b110, 3'b110};
	localparam logic [PIN_W-1:0] LVL_PATTERN [SLOT_MAX] =
		'{3'b010, 3'b001, 3'b001, 3'b100, 3'b100, 3'b010};
	localparam logic signed [PHASE_W-1:0] PHASE_INIT [SLOT_MAX] =
		'{4'sd3, 4'sd4, 4'sd3, 4'sd2, 4'sd1, 4'sd0};
	localparam logic [LEVEL_W-1:0] LEVEL_INIT [LEVEL_STEPS] =
		'{8'd0, 8'd49, 8'd141, 8'd212, 8'd255};
	localparam logic [INTERVAL_W-1:0] INTERVAL_INIT = 16'd2048;

	localparam logic signed [PHASE_W-1:0] PHASE_PEAK = 4'sd4;
	localparam logic signed [PHASE_W-1:0] PHASE_LOW  = -4'sd3;

	typedef enum logic [2:0] {
		REG_LEVEL0   = 3'd0,
		REG_LEVEL1   = 3'd1,
		REG_LEVEL2   = 3'd2,
		REG_LEVEL3   = 3'd3,
		REG_LEVEL4   = 3'd4,
		REG_INTERVAL = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic              load;
		logic              last;
		logic              advance;
		logic [SLOT_W-1:0] slot;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} sts_t;

	typedef struct packed {
		logic                  we;
		reg_idx_t              idx;
		logic [APB_DATA_W-1:0] wdata;
	} cfg_wr_t;

endpackage

FILE: rtl/core/cpbpwm_ctrl.sv
// ----------------------------------------------------------------------------
// cpbpwm_ctrl
// Scan sequencer: takes a pass request and steps the slot index once per
// free output cycle, then tells the datapath to close the pass.
// ----------------------------------------------------------------------------
module cpbpwm_ctrl #(
	parameter int LED_COUNT = cpbpwm_pkg::LED_COUNT_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_tick,
	output logic               in_ready,
	input  cpbpwm_pkg::sts_t   sts,
	output cpbpwm_pkg::cmd_t   cmd
);
	import cpbpwm_pkg::*;

	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(LED_COUNT - 1);

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} state_t;

	state_t            state_q;
	logic [SLOT_W-1:0] slot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			slot_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid && in_tick) begin
						state_q <= ST_SCAN;
						slot_q  <= '0;
					end
				end
				ST_SCAN: begin
					if (cmd.load) begin
						if (cmd.last) begin
							state_q <= ST_IDLE;
						end else begin
							slot_q <= slot_q + 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_ready    = (state_q == ST_IDLE);
	assign cmd.load    = (state_q == ST_SCAN) && sts.out_free;
	assign cmd.last    = (slot_q == LAST_SLOT);
	assign cmd.advance = cmd.load && cmd.last;
	assign cmd.slot    = slot_q;

	a_load_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> sts.out_free)
		else $error("slot loaded while output register held");
	a_no_accept_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !cmd.load)
		else $error("input taken during a scan");
	a_slot_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> (cmd.slot <= LAST_SLOT))
		else $error("slot index past last led");
	a_idle_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.advance |=> in_ready)
		else $error("sequencer not idle after last slot");

endmodule

FILE: rtl/core/cpbpwm_dp.sv
// ----------------------------------------------------------------------------
// cpbpwm_dp
// Datapath: level and interval registers, per-led phases, pwm and pass
// counters, brightness compare and the output register.
// ----------------------------------------------------------------------------
module cpbpwm_dp #(
	parameter int LED_COUNT = cpbpwm_pkg::LED_COUNT_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  cpbpwm_pkg::cfg_wr_t                     cfg_wr,
	input  cpbpwm_pkg::reg_idx_t                    rd_idx,
	output logic [cpbpwm_pkg::APB_DATA_W-1:0]       rd_data,
	input  cpbpwm_pkg::cmd_t                        cmd,
	output cpbpwm_pkg::sts_t                        sts,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic [cpbpwm_pkg::OUT_DATA_W-1:0]       out_data,
	output logic                                    out_last
);
	import cpbpwm_pkg::*;

	logic [LEVEL_W-1:0]             level_q [LEVEL_STEPS];
	logic [INTERVAL_W-1:0]          interval_q;
	logic signed [PHASE_W-1:0]      phase_q [SLOT_MAX];
	logic [LEVEL_W-1:0]             pwm_q;
	logic [INTERVAL_W-1:0]          pass_q;
	logic                           out_valid_q;
	logic [OUT_DATA_W-1:0]          out_data_q;
	logic                           out_last_q;

	logic signed [PHASE_W-1:0]      cur_phase;
	logic [PHASE_W-1:0]             mag;
	logic [2:0]                     lvl_idx;
	logic [LEVEL_W-1:0]             bright;
	logic                           led_on;
	logic [PIN_W-1:0]               pin_dir;
	logic [PIN_W-1:0]               pin_lvl;
	logic [INTERVAL_W:0]            pass_next;
	logic                           wrap;

	assign cur_phase = phase_q[cmd.slot];
	assign mag       = (cur_phase < 0) ? PHASE_W'(-cur_phase) : PHASE_W'(cur_phase);
	assign lvl_idx   = (mag > 4'd4) ? 3'd4 : mag[2:0];
	assign bright    = level_q[lvl_idx];
	assign led_on    = (pwm_q < bright);
	assign pin_dir   = DIR_PATTERN[cmd.slot];
	assign pin_lvl   = led_on ? LVL_PATTERN[cmd.slot] : '0;
	assign pass_next = {1'b0, pass_q} + 1'b1;
	assign wrap      = (pass_next >= {1'b0, interval_q});

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LEVEL_STEPS; i++) begin
				level_q[i] <= LEVEL_INIT[i];
			end
			interval_q <= INTERVAL_INIT;
		end else if (cfg_wr.we) begin
			unique case (cfg_wr.idx)
				REG_LEVEL0:   level_q[0] <= cfg_wr.wdata[LEVEL_W-1:0];
				REG_LEVEL1:   level_q[1] <= cfg_wr.wdata[LEVEL_W-1:0];
				REG_LEVEL2:   level_q[2] <= cfg_wr.wdata[LEVEL_W-1:0];
				REG_LEVEL3:   level_q[3] <= cfg_wr.wdata[LEVEL_W-1:0];
				REG_LEVEL4:   level_q[4] <= cfg_wr.wdata[LEVEL_W-1:0];
				REG_INTERVAL: interval_q <= cfg_wr.wdata[INTERVAL_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (rd_idx)
			REG_LEVEL0:   rd_data = APB_DATA_W'(level_q[0]);
			REG_LEVEL1:   rd_data = APB_DATA_W'(level_q[1]);
			REG_LEVEL2:   rd_data = APB_DATA_W'(level_q[2]);
			REG_LEVEL3:   rd_data = APB_DATA_W'(level_q[3]);
			REG_LEVEL4:   rd_data = APB_DATA_W'(level_q[4]);
			REG_INTERVAL: rd_data = APB_DATA_W'(interval_q);
			default:      rd_data = '0;
		endcase
	end

	// pass state, updated once the last slot is loaded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pwm_q  <= '0;
			pass_q <= '0;
			for (int i = 0; i < SLOT_MAX; i++) begin
				phase_q[i] <= PHASE_INIT[i];
			end
		end else if (cmd.advance) begin
			pwm_q <= pwm_q + 1'b1;
			if (wrap) begin
				pass_q <= '0;
				for (int i = 0; i < SLOT_MAX; i++) begin
					phase_q[i] <= (phase_q[i] >= PHASE_PEAK) ? PHASE_LOW
						: phase_q[i] + 4'sd1;
				end
			end else begin
				pass_q <= pass_next[INTERVAL_W-1:0];
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			out_data_q <= OUT_DATA_W'({pin_lvl, pin_dir, cmd.slot});
			out_last_q <= cmd.last;
		end
	end

	assign sts.out_free = !out_valid_q || out_ready;
	assign out_valid    = out_valid_q;
	assign out_data     = out_data_q;
	assign out_last     = out_last_q;

	a_last_on_final_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_last_q) |-> (out_data_q[SLOT_W-1:0] == SLOT_W'(LED_COUNT - 1)))
		else $error("last marker on wrong slot");

endmodule

FILE: rtl/core/charlieplex_breathing_pwm_driver_core.sv
// ----------------------------------------------------------------------------
// charlieplex_breathing_pwm_driver_core
// Six-led charlieplex scan driver with software pwm and breathing phases.
// ----------------------------------------------------------------------------
// Every input transfer with tick set starts one scan pass that sends
// LED_COUNT output transfers, one per led slot in order 0 up, the last one
// flagged by m_tlast; a transfer with tick clear is taken and produces
// nothing. The slot sequencer loads one slot per cycle into the output
// register whenever the register has room, so a low m_tready stalls the pass;
// s_tready stays low while a pass runs and no new request is taken; the
// input is ready again as soon as the last slot is loaded. Brightness per
// led comes from the level registers selected by the magnitude of its phase,
// and a led drives its level pattern only while the 8-bit pwm count is below
// that brightness. The pwm count steps after every pass, and all phases step
// each time phase_interval passes have completed. Registers sit at byte
// address 4*i: level_step0..4 then phase_interval.
module charlieplex_breathing_pwm_driver_core #(
	parameter int LED_COUNT = cpbpwm_pkg::LED_COUNT_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// s_tdata: [0] tick
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [cpbpwm_pkg::IN_DATA_W-1:0]    s_tdata,
	// m_tdata: [2:0] led_slot, [5:3] pin_direction, [8:6] pin_level
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [cpbpwm_pkg::OUT_DATA_W-1:0]   m_tdata,
	output logic                                m_tlast,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [cpbpwm_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [cpbpwm_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [cpbpwm_pkg::APB_DATA_W-1:0]   prdata,
	output logic                                pready
);
	import cpbpwm_pkg::*;

	cmd_t     cmd;
	sts_t     sts;
	cfg_wr_t  cfg_wr;
	reg_idx_t reg_idx;

	assign pready       = 1'b1;
	assign reg_idx      = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
	assign cfg_wr.we    = psel && penable && pwrite && pready;
	assign cfg_wr.idx   = reg_idx;
	assign cfg_wr.wdata = pwdata;

	cpbpwm_ctrl #(
		.LED_COUNT (LED_COUNT)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_tick  (s_tdata[0]),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	cpbpwm_dp #(
		.LED_COUNT (LED_COUNT)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr    (cfg_wr),
		.rd_idx    (reg_idx),
		.rd_data   (prdata),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata),
		.out_last  (m_tlast)
	);

endmodule
